// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SMV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");

// Expression must never be true outside reset.
`define SMV_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition");

`endif

// ===== rtl/smv_pkg.sv =====
package smv_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W = 6;
  localparam int CNT_W = 7;
  localparam int LOGIT_W = 16;
  localparam int SUM_W = 24;
  localparam int NUM_W = 33;
  localparam int DIV_CNT_W = 6;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [16:0] EXP_CUTOFF = 17'd4096;

  // 2^(-i/16) in Q1.16, i = 0..16
  function automatic logic [16:0] pow2_frac(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:  r = 17'd65536;
      5'd1:  r = 17'd62757;
      5'd2:  r = 17'd60097;
      5'd3:  r = 17'd57549;
      5'd4:  r = 17'd55109;
      5'd5:  r = 17'd52773;
      5'd6:  r = 17'd50535;
      5'd7:  r = 17'd48393;
      5'd8:  r = 17'd46341;
      5'd9:  r = 17'd44376;
      5'd10: r = 17'd42495;
      5'd11: r = 17'd40693;
      5'd12: r = 17'd38968;
      5'd13: r = 17'd37316;
      5'd14: r = 17'd35734;
      5'd15: r = 17'd34219;
      5'd16: r = 17'd32768;
      default: r = 17'd32768;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/softmax_vector_unit.sv =====
// Softmax over one vector of signed Q8.8 logits. Elements stream in one per
// transfer and are written to a 64-entry RAM; tlast ends the vector. Then
// two passes run over the RAM: one exponential per entry in a read plus
// three-stage unit for the sum pass, and per entry a second exponential plus
// a bit-serial divider and an output state in the output pass, which waits
// for as long as m_tready stays low. Results leave in input order as Q0.16
// probabilities, tlast on the final one; tuser flags that elements beyond 64
// were dropped. No input is taken while results are made.
module softmax_vector_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] logit
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] probability, [21:16] position
  output logic        m_tlast,
  output logic        m_tuser    // [0] overflowed
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_E1   = 3'd2;
  localparam logic [2:0] ST_E2   = 3'd3;
  localparam logic [2:0] ST_E3   = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [smv_pkg::LOGIT_W-1:0] mem [smv_pkg::MAX_LEN];
  logic [smv_pkg::LOGIT_W-1:0] rdata;

  logic [2:0] state;
  logic [smv_pkg::CNT_W-1:0] count;
  logic dropped;
  logic signed [smv_pkg::LOGIT_W-1:0] run_max;
  logic [smv_pkg::SUM_W-1:0] sum;
  logic [smv_pkg::ADDR_W-1:0] idx;
  logic pass2;

  logic cut1, cut2;
  logic [29:0] prod1;
  logic [4:0] shamt;
  logic [16:0] hi;
  logic [23:0] prod2;

  logic [smv_pkg::NUM_W-1:0] num;
  logic [smv_pkg::SUM_W-1:0] rem;
  logic [16:0] quo;
  logic [smv_pkg::DIV_CNT_W-1:0] div_cnt;

  logic in_xfer, store_ok, is_final;
  logic signed [smv_pkg::LOGIT_W:0] diff;
  logic [16:0] u;
  logic [20:0] t;
  logic [4:0] tidx;
  logic [16:0] lo_val;
  logic [11:0] step;
  logic [16:0] v;
  logic [23:0] shifted;
  logic [smv_pkg::SUM_W:0] r2;

  assign s_tready = (state == ST_LOAD);
  assign in_xfer = s_tvalid && s_tready;
  assign store_ok = (count < smv_pkg::CNT_W'(smv_pkg::MAX_LEN));
  assign is_final = ({1'b0, idx} + 1'b1) == count;

  always_comb begin
    diff = $signed({run_max[smv_pkg::LOGIT_W-1], run_max})
         - $signed({rdata[smv_pkg::LOGIT_W-1], rdata});
    u = 17'(diff);
    t = 21'((prod1 + 30'd128) >> 8);
    tidx = {1'b0, t[15:12]};
    lo_val = smv_pkg::pow2_frac(tidx + 5'd1);
    step = 12'(smv_pkg::pow2_frac(tidx) - lo_val);
    v = hi - 17'((prod2 + 24'd2048) >> 12);
    shifted = (shamt == 5'd0) ? {7'd0, v}
            : ({7'd0, v} + (24'd1 << (shamt - 5'd1))) >> shamt;
    r2 = {rem, num[smv_pkg::NUM_W-1]};
  end

  // Loading and the passes never overlap, so RAM needs no forwarding.
  always_ff @(posedge clk) begin
    if (in_xfer && store_ok) begin
      mem[count[smv_pkg::ADDR_W-1:0]] <= s_tdata;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    prod1 <= 30'(u[12:0]) * 30'(smv_pkg::LOG2E_Q16);
    cut1 <= (u > smv_pkg::EXP_CUTOFF);
    shamt <= t[20:16];
    hi <= smv_pkg::pow2_frac(tidx);
    prod2 <= 24'(step) * 24'(t[11:0]);
    cut2 <= cut1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      dropped <= 1'b0;
      run_max <= 16'sh8000;
      sum <= '0;
      idx <= '0;
      pass2 <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (store_ok) begin
              count <= count + 1'b1;
              if ($signed(s_tdata) > run_max) begin
                run_max <= $signed(s_tdata);
              end
            end else begin
              dropped <= 1'b1;
            end
            if (s_tlast) begin
              idx <= '0;
              sum <= '0;
              pass2 <= 1'b0;
              state <= ST_RD;
            end
          end
        end
        ST_RD: state <= ST_E1;
        ST_E1: state <= ST_E2;
        ST_E2: state <= ST_E3;
        ST_E3: begin
          if (!pass2) begin
            sum <= sum + 24'(cut2 ? 24'd0 : shifted);
            if (is_final) begin
              idx <= '0;
              pass2 <= 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
            state <= ST_RD;
          end else begin
            num <= {(cut2 ? 17'd0 : 17'(shifted)), 16'd0} + 33'(sum >> 1);
            rem <= '0;
            quo <= '0;
            div_cnt <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (r2 >= {1'b0, sum}) begin
            rem <= smv_pkg::SUM_W'(r2 - {1'b0, sum});
            quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= r2[smv_pkg::SUM_W-1:0];
            quo <= {quo[15:0], 1'b0};
          end
          num <= {num[smv_pkg::NUM_W-2:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == smv_pkg::DIV_CNT_W'(smv_pkg::NUM_W - 1)) begin
            state <= ST_OUT;
            m_tvalid <= 1'b1;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (is_final) begin
              count <= '0;
              dropped <= 1'b0;
              run_max <= 16'sh8000;
              state <= ST_LOAD;
            end else begin
              idx <= idx + 1'b1;
              state <= ST_RD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign m_tdata = {2'b00, idx, (quo[16] ? 16'hFFFF : quo[15:0])};
  assign m_tlast = is_final;
  assign m_tuser = dropped;

endmodule

// ===== rtl/smv_checker.sv =====
`include "assert_macros.svh"

module smv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  `SMV_ASSERT(a_out_hold, clk, rst,
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
  `SMV_NEVER(a_no_overlap, clk, rst, s_tready && m_tvalid)
  `SMV_ASSERT(a_last_in_stops, clk, rst, (s_tvalid && s_tready && s_tlast) |=> !s_tready)
  `SMV_ASSERT(a_last_out_frees, clk, rst,
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))

endmodule

bind softmax_vector_unit smv_checker u_smv_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

// ===== sim/softmax_vector_unit_tb.sv =====
module softmax_vector_unit_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  typedef struct packed {
    logic [15:0] logit;
    logic        last;
  } elem_t;

  typedef struct packed {
    logic [15:0] probability;
    logic [5:0]  position;
    logic        last;
    logic        overflowed;
  } prob_t;

  softmax_vector_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  localparam int WATCHDOG = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int MODE_FULL = 0;
  localparam int MODE_NARROW = 1;
  localparam int MODE_MID = 2;

  elem_t       pending_elems[$];
  prob_t       expected_probs[$];
  logic [15:0] vec_logits[smv_pkg::MAX_LEN];
  int          vec_count = 0;
  logic        vec_dropped = 1'b0;
  int          vec_max = -32768;
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 28;
  int          recv_idle_pct = 73;
  logic        in_acc = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold = 1'b0;

  function automatic int unsigned table_pow2(int unsigned i);
    int unsigned t[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                           46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                           32768};
    return t[i];
  endfunction

  function automatic longint unsigned exp_of_neg(longint unsigned u);
    longint unsigned t, n, f, hi, lo, v;
    if (u > 4096) return 0;
    t = (u * 94548 + 128) >> 8;
    n = t >> 16;
    f = t & 16'hFFFF;
    hi = table_pow2(32'((f >> 12) & 15));
    lo = table_pow2(32'(((f >> 12) & 15) + 1));
    v = hi - (((hi - lo) * (f & 12'hFFF) + 2048) >> 12);
    if (n == 0) return v;
    if (n >= 31) return 0;
    return (v + (64'd1 << (n - 1))) >> n;
  endfunction

  task automatic predict_softmax(input elem_t e);
    longint unsigned sum, ex, p;
    int x, i;
    prob_t r;
    x = $signed(e.logit);
    if (vec_count < smv_pkg::MAX_LEN) begin
      vec_logits[vec_count] = e.logit;
      vec_count++;
      if (x > vec_max) vec_max = x;
    end else begin
      vec_dropped = 1'b1;
    end
    if (!e.last) return;
    sum = 0;
    for (i = 0; i < vec_count; i++)
      sum += exp_of_neg(vec_max - $signed(vec_logits[i]));
    for (i = 0; i < vec_count; i++) begin
      ex = exp_of_neg(vec_max - $signed(vec_logits[i]));
      p = ((ex << 16) + (sum >> 1)) / sum;
      if (p > 65535) p = 65535;
      r.probability = p[15:0];
      r.position = i[5:0];
      r.last = (i + 1 == vec_count);
      r.overflowed = vec_dropped;
      expected_probs = {expected_probs, r};
    end
    vec_count = 0;
    vec_dropped = 1'b0;
    vec_max = -32768;
  endtask

  task automatic queue_elem(input logic [15:0] logit, input logic last);
    elem_t e;
    e.logit = logit;
    e.last = last;
    pending_elems = {pending_elems, e};
  endtask

  task automatic add_vector(input int len, input int mode);
    logic [15:0] logit;
    int i;
    for (i = 0; i < len; i++) begin
      case (mode)
        MODE_FULL: logit = 16'($urandom);
        MODE_NARROW: logit = 16'(int'($urandom_range(0, 2047)) - 1024);
        default: logit = 16'(int'($urandom_range(0, 8191)) - 4096);
      endcase
      queue_elem(logit, (i == len - 1));
    end
  endtask

  // long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_acc) begin
        if (pending_elems.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_elems[0].logit;
          s_tlast <= pending_elems[0].last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (hold) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    prob_t got, want;
    in_acc <= s_tvalid && s_tready;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (s_tvalid && s_tready) begin
        predict_softmax(pending_elems.pop_front());
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[21:16], m_tlast, m_tuser};
        if (expected_probs.size() == 0) begin
          $error("unexpected result: %h", got);
          errors++;
        end else begin
          want = expected_probs.pop_front();
          if (got.probability !== want.probability) begin
            $error("probability: expected %0d actual %0d", want.probability, got.probability);
            errors++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d actual %0d", want.position, got.position);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last_out: expected %0d actual %0d", want.last, got.last);
            errors++;
          end
          if (got.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0d actual %0d", want.overflowed, got.overflowed);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_elems.size() > 0 || expected_probs.size() > 0) @(posedge clk);
  endtask

  initial begin
    int k;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    // directed
    queue_elem(16'h8000, 1'b1);
    queue_elem(16'h7FFF, 1'b0);
    queue_elem(16'h8000, 1'b0);
    queue_elem(16'h0000, 1'b0);
    queue_elem(16'hFFFF, 1'b1);
    queue_elem(16'h1000, 1'b0);
    queue_elem(16'h0000, 1'b0);
    queue_elem(16'h0FFF, 1'b0);
    queue_elem(16'h1000, 1'b1);
    queue_elem(16'h5555, 1'b0);
    queue_elem(16'hAAAA, 1'b1);
    drain();
    // capacity exceeded, last two elements dropped
    add_vector(66, MODE_NARROW);
    drain();
    // receiver stalls while the next vector is offered
    hold_go = 1'b1;
    add_vector(10, MODE_MID);
    add_vector(6, MODE_MID);
    drain();
    for (k = 0; k < 6; k++) add_vector($urandom_range(1, 8), $urandom_range(MODE_FULL, MODE_MID));
    drain();
    send_idle_pct = 73; recv_idle_pct = 28;
    for (k = 0; k < 6; k++) add_vector($urandom_range(1, 8), $urandom_range(MODE_FULL, MODE_MID));
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    for (k = 0; k < 6; k++) add_vector($urandom_range(1, 8), $urandom_range(MODE_FULL, MODE_MID));
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/smv_pkg.sv
rtl/softmax_vector_unit.sv
rtl/smv_checker.sv
sim/softmax_vector_unit_tb.sv
